// ===== hdl/dhcp_reply_option_parser_assert.svh =====
// Assertion macros for the DHCP reply option parser.
`ifndef DHCP_REPLY_OPTION_PARSER_ASSERT_SVH
`define DHCP_REPLY_OPTION_PARSER_ASSERT_SVH

// Clocked implication, off during reset.
`define DRP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold.
`define DRP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== hdl/drp_pkg.sv =====
package drp_pkg;

  localparam int unsigned MaxPacketDef  = 2048;
  localparam int unsigned MaxRoutersDef = 4;
  localparam int unsigned MaxDnsDef     = 3;

  localparam int unsigned ListSlots = 4;  // field_index is two bits
  localparam logic [15:0] OptStart  = 16'd240;
  localparam logic [31:0] Cookie    = 32'h6382_5363;

  localparam logic [7:0] OptPad       = 8'd0;
  localparam logic [7:0] OptNetmask   = 8'd1;
  localparam logic [7:0] OptRouter    = 8'd3;
  localparam logic [7:0] OptDns       = 8'd6;
  localparam logic [7:0] OptBroadcast = 8'd28;
  localparam logic [7:0] OptLease     = 8'd51;
  localparam logic [7:0] OptMsgType   = 8'd53;
  localparam logic [7:0] OptServer    = 8'd54;
  localparam logic [7:0] OptRenew     = 8'd58;
  localparam logic [7:0] OptRebind    = 8'd59;
  localparam logic [7:0] OptEnd       = 8'd255;

  localparam logic CfgTransactionId = 1'b0;
  localparam logic CfgClientHwAddr  = 1'b1;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_SIZE  = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    FK_NONE      = 4'd0,
    FK_ADDRESS   = 4'd1,
    FK_NETMASK   = 4'd2,
    FK_BROADCAST = 4'd3,
    FK_LEASE     = 4'd4,
    FK_RENEW     = 4'd5,
    FK_REBIND    = 4'd6,
    FK_TYPE      = 4'd7,
    FK_SERVER    = 4'd8,
    FK_ROUTER    = 4'd9,
    FK_DNS       = 4'd10
  } field_kind_e;

endpackage

// ===== hdl/dhcp_reply_option_parser.sv =====
// Channel   | Dir | Handshake             | Beat contents
// s_axis    | in  | s_tvalid_i/s_tready_o | tdata: data_byte[7:0]; tlast: last_byte
// m_axis    | out | m_tvalid_o/m_tready_i | tdata: status, field_kind, field_index,
//           |     |                       |        field_value; tlast: run_end
// cfg       | in  | cfg_valid_i/cfg_ready_o | index 0 transaction id, 1 client MAC
//
// One packet byte per cycle; header checks and option walk finish in the beat's
// own cycle. The final byte loads a result snapshot, which the output sequencer
// drains at one item per cycle: 1 item on reject, 8 + routers + DNS otherwise.
// A final byte is held off (s_tready_o low) while the previous snapshot is still
// draining; other bytes keep flowing. Output register stalls only on m_tready_i.
// Reset (rst_ni, async, low) clears the parser, the sequencer and the config registers.
module dhcp_reply_option_parser
  import drp_pkg::*;
#(
  parameter int unsigned MAX_PACKET  = MaxPacketDef,
  parameter int unsigned MAX_ROUTERS = MaxRoutersDef,
  parameter int unsigned MAX_DNS     = MaxDnsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] data_byte
  input  logic        s_tlast_i,   // last_byte
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // [0] status, [4:1] field_kind, [6:5] field_index,
                                   // [38:7] field_value, [39] zero
  output logic        m_tlast_o,   // run_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  localparam int unsigned RCapI = (MAX_ROUTERS < ListSlots) ? MAX_ROUTERS : ListSlots;
  localparam int unsigned DCapI = (MAX_DNS < ListSlots) ? MAX_DNS : ListSlots;
  localparam logic [2:0]  RCap  = 3'(RCapI);
  localparam logic [2:0]  DCap  = 3'(DCapI);
  localparam logic [15:0] MaxPkt = 16'(MAX_PACKET);

  // configuration
  logic [31:0] tid_q;
  logic [47:0] mac_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tid_q <= '0;
      mac_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgTransactionId: tid_q <= cfg_data_i[31:0];
        CfgClientHwAddr:  mac_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // parser state
  logic [15:0] pos_q, pos_d;
  logic        rej_q, rej_d;
  phase_e      ph_q, ph_d;
  logic [7:0]  code_q, code_d, size_q, size_d, left_q, left_d;
  logic [31:0] wg_q, wg_d, addr_q, addr_d, mask_q, mask_d, bc_q, bc_d;
  logic [31:0] lease_q, lease_d, renew_q, renew_d, rebind_q, rebind_d, srv_q, srv_d;
  logic [7:0]  kind_q, kind_d;
  logic [31:0] rl_q [ListSlots];
  logic [31:0] dl_q [ListSlots];
  logic [2:0]  rt_q, rt_d, dt_q, dt_d;
  logic        r_wr, d_wr;

  // snapshot and sequencer
  logic        busy_q;
  logic        s_rej_q;
  logic [31:0] s_addr_q, s_mask_q, s_bc_q, s_lease_q, s_renew_q, s_rebind_q, s_srv_q;
  logic [7:0]  s_kind_q;
  logic [31:0] s_rl_q [ListSlots];
  logic [31:0] s_dl_q [ListSlots];
  logic [2:0]  s_rt_q, s_dt_q;
  logic [3:0]  cnt_q;
  logic [4:0]  n_q;

  logic accept, fin, fin_rej;
  logic [7:0] b, want, idx;
  logic four, chk;

  assign s_tready_o = !(busy_q && s_tlast_i);
  assign accept     = s_tvalid_i && s_tready_o;
  assign b          = s_tdata_i;

  always_comb begin
    pos_d = pos_q; rej_d = rej_q; ph_d = ph_q; code_d = code_q; size_d = size_q;
    left_d = left_q; wg_d = wg_q; addr_d = addr_q; mask_d = mask_q; bc_d = bc_q;
    lease_d = lease_q; renew_d = renew_q; rebind_d = rebind_q; srv_d = srv_q;
    kind_d = kind_q; rt_d = rt_q; dt_d = dt_q;
    r_wr = 1'b0; d_wr = 1'b0;
    want = '0; chk = 1'b0;
    idx  = size_q - left_q;
    four = (size_q == 8'd4) && (idx == 8'd3);

    if (pos_q >= MaxPkt) rej_d = 1'b1;
    if (!rej_d) begin
      if (pos_q < OptStart) begin
        // header bytes
        if (pos_q == 16'd0) begin
          chk = 1'b1; want = 8'd2;
        end else if (pos_q == 16'd1) begin
          chk = 1'b1; want = 8'd1;
        end else if (pos_q == 16'd2) begin
          chk = 1'b1; want = 8'd6;
        end else if (pos_q >= 16'd4 && pos_q <= 16'd7) begin
          chk = 1'b1; want = 8'(tid_q >> {~pos_q[1:0], 3'b000});
        end else if (pos_q >= 16'd16 && pos_q <= 16'd19) begin
          addr_d = {addr_q[23:0], b};
        end else if (pos_q >= 16'd28 && pos_q <= 16'd33) begin
          chk = 1'b1; want = 8'(mac_q >> {6'(16'd33 - pos_q), 3'b000});
        end else if (pos_q >= 16'd236) begin
          chk = 1'b1; want = 8'(Cookie >> {~pos_q[1:0], 3'b000});
        end
        if (chk && b != want) rej_d = 1'b1;
      end else begin
        unique case (ph_q)
          PH_CODE: begin
            if (b == OptEnd) ph_d = PH_DONE;
            else if (b != OptPad) begin
              code_d = b; ph_d = PH_SIZE;
            end
          end
          PH_SIZE: begin
            size_d = b; left_d = b; wg_d = '0;
            ph_d = (b == 8'd0) ? PH_CODE : PH_VALUE;
          end
          PH_VALUE: begin
            wg_d   = {wg_q[23:0], b};
            left_d = left_q - 8'd1;
            priority if (code_q == OptNetmask && four)   mask_d   = wg_d;
            else if (code_q == OptBroadcast && four)     bc_d     = wg_d;
            else if (code_q == OptLease && four)         lease_d  = wg_d;
            else if (code_q == OptServer && four)        srv_d    = wg_d;
            else if (code_q == OptRenew && four)         renew_d  = wg_d;
            else if (code_q == OptRebind && four)        rebind_d = wg_d;
            else if (code_q == OptMsgType && size_q == 8'd1) kind_d = b;
            else if (code_q == OptRouter && idx[1:0] == 2'd3 && rt_q < RCap) begin
              r_wr = 1'b1; rt_d = rt_q + 3'd1;
            end else if (code_q == OptDns && idx[1:0] == 2'd3 && dt_q < DCap) begin
              d_wr = 1'b1; dt_d = dt_q + 3'd1;
            end else begin
              // other codes and sizes: byte skipped
            end
            if (left_d == 8'd0) ph_d = PH_CODE;
          end
          PH_DONE: ;
          default: ;
        endcase
      end
    end
    if (pos_q != 16'hFFFF) pos_d = pos_q + 16'd1;
  end

  assign fin     = accept && s_tlast_i;
  assign fin_rej = rej_d || (pos_q < OptStart) || ph_d == PH_SIZE || ph_d == PH_VALUE
                   || kind_d == 8'd0 || addr_d == 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; rej_q <= 1'b0; ph_q <= PH_CODE; code_q <= '0; size_q <= '0;
      left_q <= '0; wg_q <= '0; addr_q <= '0; mask_q <= '0; bc_q <= '0;
      lease_q <= '0; renew_q <= '0; rebind_q <= '0; srv_q <= '0; kind_q <= '0;
      rt_q <= '0; dt_q <= '0;
    end else if (fin) begin
      pos_q <= '0; rej_q <= 1'b0; ph_q <= PH_CODE; code_q <= '0; size_q <= '0;
      left_q <= '0; wg_q <= '0; addr_q <= '0; mask_q <= '0; bc_q <= '0;
      lease_q <= '0; renew_q <= '0; rebind_q <= '0; srv_q <= '0; kind_q <= '0;
      rt_q <= '0; dt_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d; rej_q <= rej_d; ph_q <= ph_d; code_q <= code_d; size_q <= size_d;
      left_q <= left_d; wg_q <= wg_d; addr_q <= addr_d; mask_q <= mask_d; bc_q <= bc_d;
      lease_q <= lease_d; renew_q <= renew_d; rebind_q <= rebind_d; srv_q <= srv_d;
      kind_q <= kind_d; rt_q <= rt_d; dt_q <= dt_d;
    end
  end

  // list entries: payload only, count says which are live
  always_ff @(posedge clk_i) begin
    if (accept && r_wr) rl_q[rt_q[1:0]] <= wg_d;
    if (accept && d_wr) dl_q[dt_q[1:0]] <= wg_d;
  end

  // snapshot payload, with the list entry written by the final byte folded in
  always_ff @(posedge clk_i) begin
    if (fin) begin
      s_rej_q    <= fin_rej;
      s_addr_q   <= addr_d;
      s_mask_q   <= mask_d;
      s_bc_q     <= (bc_d == 32'd0 && mask_d != 32'd0) ? (addr_d | ~mask_d) : bc_d;
      s_lease_q  <= lease_d;
      s_renew_q  <= renew_d;
      s_rebind_q <= rebind_d;
      s_srv_q    <= srv_d;
      s_kind_q   <= kind_d;
      s_rt_q     <= rt_d;
      s_dt_q     <= dt_d;
      for (int i = 0; i < ListSlots; i++) begin
        s_rl_q[i] <= (r_wr && rt_q[1:0] == 2'(i)) ? wg_d : rl_q[i];
        s_dl_q[i] <= (d_wr && dt_q[1:0] == 2'(i)) ? wg_d : dl_q[i];
      end
    end
  end

  // output sequencer
  logic        adv, m_valid_q, m_last_q;
  logic [39:0] m_data_q;
  logic        o_last;
  field_kind_e o_kind;
  logic [1:0]  o_idx;
  logic [31:0] o_val;
  logic [4:0]  cnt_x, r_end;

  assign adv   = busy_q && (!m_valid_q || m_tready_i);
  assign cnt_x = {1'b0, cnt_q};
  assign r_end = 5'd8 + {2'b0, s_rt_q};

  always_comb begin
    o_kind = FK_NONE; o_idx = '0; o_val = '0;
    if (!s_rej_q) begin
      if (cnt_x < 5'd8) begin
        o_kind = field_kind_e'(cnt_q + 4'd1);
        unique case (cnt_q[2:0])
          3'd0: o_val = s_addr_q;
          3'd1: o_val = s_mask_q;
          3'd2: o_val = s_bc_q;
          3'd3: o_val = s_lease_q;
          3'd4: o_val = s_renew_q;
          3'd5: o_val = s_rebind_q;
          3'd6: o_val = {24'd0, s_kind_q};
          default: o_val = s_srv_q;
        endcase
      end else if (cnt_x < r_end) begin
        o_kind = FK_ROUTER;
        o_idx  = 2'(cnt_x - 5'd8);
        o_val  = s_rl_q[o_idx];
      end else begin
        o_kind = FK_DNS;
        o_idx  = 2'(cnt_x - r_end);
        o_val  = s_dl_q[o_idx];
      end
    end
    o_last = (cnt_x == n_q - 5'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      n_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (fin) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        n_q    <= fin_rej ? 5'd1 : (5'd8 + {2'b0, rt_d} + {2'b0, dt_d});
      end else if (adv) begin
        cnt_q <= cnt_q + 4'd1;
        if (o_last) busy_q <= 1'b0;
      end
      if (adv) m_valid_q <= 1'b1;
      else if (m_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= {1'b0, o_val, o_idx, o_kind, s_rej_q};
      m_last_q <= o_last;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tlast_o  = m_last_q;

  `include "dhcp_reply_option_parser_assert.svh"

  `DRP_ASSERT_IMPLY(a_no_fin_while_busy, busy_q && s_tlast_i, !s_tready_o, "final byte taken")
  `DRP_ASSERT_IMPLY(a_cnt_in_run, busy_q, cnt_x < n_q, "sequencer past end of run")
  `DRP_ASSERT_NEVER(a_list_caps, rt_q > RCap || dt_q > DCap, "list count over cap")
  `DRP_ASSERT_IMPLY(a_rej_single, busy_q && s_rej_q, n_q == 5'd1, "reject run too long")

endmodule

// ===== test/dhcp_reply_option_parser_tb.sv =====
module dhcp_reply_option_parser_tb;
  import drp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One lease field as it leaves the parser.
  typedef struct packed {
    logic        status;
    field_kind_e kind;
    logic [1:0]  index;
    logic [31:0] value;
    logic        run_end;
  } lease_item_t;

  localparam int MaxPacket = MaxPacketDef;
  localparam int RouterCap = (MaxRoutersDef < ListSlots) ? MaxRoutersDef : ListSlots;
  localparam int DnsCap    = (MaxDnsDef < ListSlots) ? MaxDnsDef : ListSlots;
  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i = '0;
  logic        s_tlast_i = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [39:0] m_tdata_o;
  logic        m_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [47:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  dhcp_reply_option_parser u_dut (.*);

  // Predictor state: mirrors the parser's per-packet registers.
  logic [31:0] xid_reg;
  logic [47:0] mac_reg;
  int unsigned pos_cnt;
  logic        rejected;
  phase_e      phase;
  logic [7:0]  opt_code, opt_size, opt_left;
  logic [31:0] gather, addr, mask, bcast, lease, renew, rebind, server;
  logic [7:0]  msg_kind;
  logic [31:0] routers [ListSlots];
  logic [31:0] dns     [ListSlots];
  int unsigned n_router, n_dns;

  lease_item_t lease_fifo[$];
  int          errors;
  int          results_seen;
  int          packets_sent, rejects_seen;
  bit          idle_off;      // long stretch without random gaps
  bit          hold_sink;     // receiver held off for a stretch
  bit          drain_wait;

  task automatic clear_packet();
    pos_cnt = 0; rejected = 1'b0; phase = PH_CODE;
    opt_code = '0; opt_size = '0; opt_left = '0; gather = '0;
    addr = '0; mask = '0; bcast = '0; lease = '0; renew = '0; rebind = '0;
    server = '0; msg_kind = '0; n_router = 0; n_dns = 0;
    for (int i = 0; i < ListSlots; i++) begin
      routers[i] = '0;
      dns[i] = '0;
    end
  endtask

  function automatic lease_item_t mk(logic st, field_kind_e k, int idx, logic [31:0] v);
    lease_item_t it;
    it.status = st; it.kind = k; it.index = idx[1:0]; it.value = v; it.run_end = 1'b0;
    return it;
  endfunction

  // Header byte checks; offered address gathered from bytes 16..19.
  task automatic check_header(int unsigned p, logic [7:0] b);
    logic [31:0] c;
    c = Cookie;
    if (p == 0 && b != 8'd2) rejected = 1'b1;
    else if (p == 1 && b != 8'd1) rejected = 1'b1;
    else if (p == 2 && b != 8'd6) rejected = 1'b1;
    else if (p >= 4 && p <= 7) begin
      if (b != xid_reg[8*(7-p) +: 8]) rejected = 1'b1;
    end else if (p >= 16 && p <= 19) addr = {addr[23:0], b};
    else if (p >= 28 && p <= 33) begin
      if (b != mac_reg[8*(33-p) +: 8]) rejected = 1'b1;
    end else if (p >= 236 && p <= 239) begin
      if (b != c[8*(239-p) +: 8]) rejected = 1'b1;
    end
  endtask

  task automatic walk_option(logic [7:0] b);
    logic [7:0] idx;
    logic       four;
    case (phase)
      PH_CODE: begin
        if (b == OptEnd) phase = PH_DONE;
        else if (b != OptPad) begin
          opt_code = b;
          phase = PH_SIZE;
        end
      end
      PH_SIZE: begin
        opt_size = b; opt_left = b; gather = '0;
        phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
      end
      PH_VALUE: begin
        idx = opt_size - opt_left;
        four = (opt_size == 8'd4) && (idx == 8'd3);
        gather = {gather[23:0], b};
        opt_left = opt_left - 8'd1;
        if (opt_code == OptNetmask && four) mask = gather;
        else if (opt_code == OptBroadcast && four) bcast = gather;
        else if (opt_code == OptLease && four) lease = gather;
        else if (opt_code == OptServer && four) server = gather;
        else if (opt_code == OptRenew && four) renew = gather;
        else if (opt_code == OptRebind && four) rebind = gather;
        else if (opt_code == OptMsgType && opt_size == 8'd1) msg_kind = b;
        else if (opt_code == OptRouter && idx[1:0] == 2'd3 && n_router < RouterCap) begin
          routers[n_router] = gather;
          n_router++;
        end else if (opt_code == OptDns && idx[1:0] == 2'd3 && n_dns < DnsCap) begin
          dns[n_dns] = gather;
          n_dns++;
        end
        if (opt_left == 8'd0) phase = PH_CODE;
      end
      default: ;
    endcase
  endtask

  // Works out the lease run (or reject) caused by one accepted byte.
  task automatic predict_byte(logic [7:0] b, logic last);
    int unsigned p;
    lease_item_t run[$];
    p = pos_cnt;
    if (p >= MaxPacket) rejected = 1'b1;
    if (!rejected) begin
      if (p < OptStart) check_header(p, b);
      else walk_option(b);
    end
    if (pos_cnt < 16'hFFFF) pos_cnt++;
    if (!last) return;
    if (p < OptStart || phase == PH_SIZE || phase == PH_VALUE || msg_kind == 0 || addr == 0)
      rejected = 1'b1;
    if (rejected) run.push_back(mk(1'b1, FK_NONE, 0, '0));
    else begin
      if (bcast == 0 && mask != 0) bcast = addr | ~mask;
      run.push_back(mk(1'b0, FK_ADDRESS, 0, addr));
      run.push_back(mk(1'b0, FK_NETMASK, 0, mask));
      run.push_back(mk(1'b0, FK_BROADCAST, 0, bcast));
      run.push_back(mk(1'b0, FK_LEASE, 0, lease));
      run.push_back(mk(1'b0, FK_RENEW, 0, renew));
      run.push_back(mk(1'b0, FK_REBIND, 0, rebind));
      run.push_back(mk(1'b0, FK_TYPE, 0, {24'd0, msg_kind}));
      run.push_back(mk(1'b0, FK_SERVER, 0, server));
      for (int i = 0; i < n_router; i++) run.push_back(mk(1'b0, FK_ROUTER, i, routers[i]));
      for (int i = 0; i < n_dns; i++) run.push_back(mk(1'b0, FK_DNS, i, dns[i]));
    end
    run[run.size()-1].run_end = 1'b1;
    foreach (run[i]) lease_fifo.push_back(run[i]);
    clear_packet();
  endtask

  task automatic report(string what, lease_item_t got, lease_item_t exp);
    errors++;
    $display("tb: mismatch %s at %0t: got st=%0b k=%0d i=%0d v=%h e=%0b, exp st=%0b k=%0d i=%0d v=%h e=%0b",
             what, $realtime, got.status, got.kind, got.index, got.value, got.run_end,
             exp.status, exp.kind, exp.index, exp.value, exp.run_end);
  endtask

  // ---------------------------------------------------------------------
  // Output side: random back-pressure, checks each accepted beat.
  // ---------------------------------------------------------------------
  int idle_cnt;

  always @(posedge clk_i) begin
    lease_item_t got, exp;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        got.status = m_tdata_o[0];
        got.kind = field_kind_e'(m_tdata_o[4:1]);
        got.index = m_tdata_o[6:5];
        got.value = m_tdata_o[38:7];
        got.run_end = m_tlast_o;
        results_seen++;
        if (got.status) rejects_seen++;
        if (lease_fifo.size() == 0) report("unexpected beat", got, got);
        else begin
          exp = lease_fifo.pop_front();
          if (got !== exp || m_tdata_o[39] !== 1'b0) report("field", got, exp);
        end
      end
      if (hold_sink) m_tready_i <= 1'b0;
      else m_tready_i <= idle_off ? 1'b1 : ($urandom_range(99) >= 31);
    end
  end

  // Watchdog: cycles without any accepted beat on either side.
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cnt <= 0;
    else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("tb: watchdog expired");
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic last);
    while (!idle_off && $urandom_range(99) < 31) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= b;
    s_tlast_i <= last;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    predict_byte(b, last);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (lease_fifo.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [47:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CfgTransactionId) xid_reg = v[31:0];
    else mac_reg = v;
  endtask

  // Packet builder. Options are appended as raw bytes after the header.
  logic [7:0] pkt[$];

  function automatic void build_header(logic [31:0] xid, logic [47:0] mac, logic [31:0] yiaddr);
    logic [31:0] c;
    c = Cookie;
    pkt.delete();
    for (int i = 0; i < 240; i++) pkt.push_back($urandom_range(255));
    pkt[0] = 8'd2; pkt[1] = 8'd1; pkt[2] = 8'd6;
    for (int i = 0; i < 4; i++) pkt[4+i] = xid[8*(3-i) +: 8];
    for (int i = 0; i < 4; i++) pkt[16+i] = yiaddr[8*(3-i) +: 8];
    for (int i = 0; i < 6; i++) pkt[28+i] = mac[8*(5-i) +: 8];
    for (int i = 0; i < 4; i++) pkt[236+i] = c[8*(3-i) +: 8];
  endfunction

  function automatic void add_opt(logic [7:0] code, int len);
    pkt.push_back(code);
    pkt.push_back(len[7:0]);
    for (int i = 0; i < len; i++) pkt.push_back($urandom_range(255));
  endfunction

  function automatic void add_word(logic [7:0] code, logic [31:0] v);
    pkt.push_back(code); pkt.push_back(8'd4);
    for (int i = 0; i < 4; i++) pkt.push_back(v[8*(3-i) +: 8]);
  endfunction

  task automatic send_pkt();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  function automatic logic [7:0] rand_code();
    case ($urandom_range(13))
      0: return OptNetmask;   1: return OptRouter;   2: return OptDns;
      3: return OptBroadcast; 4: return OptLease;    5: return OptMsgType;
      6: return OptServer;    7: return OptRenew;    8: return OptRebind;
      9: return OptPad;       10: return 8'($urandom_range(254, 60));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Reply with random options (address or message type sometimes zero); broken when errs is set.
  task automatic random_packet(int errs);
    logic [31:0] ip;
    int n, len;
    logic [7:0] code;
    ip = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
    build_header(xid_reg, mac_reg, ip);
    pkt.push_back(OptMsgType); pkt.push_back(8'd1);
    pkt.push_back(($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(255, 1)));
    n = $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      code = rand_code();
      if (code == OptPad) pkt.push_back(OptPad);
      else begin
        case ($urandom_range(3))
          0: len = 4;
          1: len = (code == OptMsgType) ? 1 : 4 * $urandom_range(6);
          2: len = $urandom_range(9);
          default: len = ($urandom_range(7) == 0) ? 255 : $urandom_range(20);
        endcase
        add_opt(code, len);
      end
    end
    if ($urandom_range(3) != 0) begin
      pkt.push_back(OptEnd);
      repeat ($urandom_range(4)) pkt.push_back($urandom_range(255));
    end
    if (errs) begin
      case ($urandom_range(3))
        0: pkt[$urandom_range(239)] ^= 8'(1 << $urandom_range(7)); // header bit flip
        1: while (pkt.size() > $urandom_range(250, 1)) void'(pkt.pop_back());
        2: begin pkt.push_back(rand_code()); end               // dangling code
        default: begin pkt.push_back(OptLease); pkt.push_back(8'd4); pkt.push_back(8'h11); end
      endcase
    end
    send_pkt();
  endtask

  // Directed table: each row names one special case; every row goes through the
  // predictor, and the reject rows also check that it predicted a reject.
  typedef enum int {
    D_MIN_ACCEPT, D_ALL_OPTS, D_LISTS_FULL, D_SHORT, D_ONE_BYTE, D_BAD_OP,
    D_BAD_HTYPE, D_BAD_HLEN, D_BAD_XID, D_BAD_MAC, D_BAD_COOKIE, D_NO_TYPE,
    D_NO_ADDR, D_TRUNC_CODE, D_TRUNC_VALUE, D_LONG, D_BCAST_DERIVED,
    D_WRONG_SIZES, D_AFTER_END, D_EXTREMES
  } dir_case_e;

  typedef struct {
    dir_case_e   which;
    bit          reject_known;   // predictor must end with a single reject beat
  } dir_row_t;

  dir_row_t dir_table[] = '{
    '{D_MIN_ACCEPT, 0}, '{D_ALL_OPTS, 0}, '{D_LISTS_FULL, 0}, '{D_SHORT, 1},
    '{D_ONE_BYTE, 1}, '{D_BAD_OP, 1}, '{D_BAD_HTYPE, 1}, '{D_BAD_HLEN, 1},
    '{D_BAD_XID, 1}, '{D_BAD_MAC, 1}, '{D_BAD_COOKIE, 1}, '{D_NO_TYPE, 1},
    '{D_NO_ADDR, 1}, '{D_TRUNC_CODE, 1}, '{D_TRUNC_VALUE, 1}, '{D_LONG, 1},
    '{D_BCAST_DERIVED, 0}, '{D_WRONG_SIZES, 0}, '{D_AFTER_END, 0}, '{D_EXTREMES, 0}
  };

  task automatic directed_row(dir_row_t row);
    build_header(xid_reg, mac_reg, 32'hC0A8_0A05);
    pkt.push_back(OptMsgType); pkt.push_back(8'd1); pkt.push_back(8'd5);
    case (row.which)
      D_ALL_OPTS: begin
        add_word(OptNetmask, 32'hFFFF_FF00); add_word(OptBroadcast, 32'hC0A8_0AFF);
        add_word(OptLease, 32'd86400); add_word(OptServer, 32'hC0A8_0A01);
        add_word(OptRenew, 32'd43200); add_word(OptRebind, 32'd75600);
        pkt.push_back(OptPad); add_opt(OptRouter, 4); add_opt(OptDns, 8);
        add_opt(8'd12, 7);
      end
      D_LISTS_FULL: begin add_opt(OptRouter, 24); add_opt(OptDns, 20); add_opt(OptRouter, 4); end
      D_SHORT: void'(pkt.pop_back());
      D_ONE_BYTE: begin pkt.delete(); pkt.push_back(8'd2); end
      D_BAD_OP: pkt[0] = 8'd1;
      D_BAD_HTYPE: pkt[1] = 8'd6;
      D_BAD_HLEN: pkt[2] = 8'd16;
      D_BAD_XID: pkt[7] ^= 8'h80;
      D_BAD_MAC: pkt[33] ^= 8'h01;
      D_BAD_COOKIE: pkt[239] = 8'h00;
      D_NO_TYPE: pkt[242] = 8'd0;
      D_NO_ADDR: for (int i = 16; i < 20; i++) pkt[i] = 8'd0;
      D_TRUNC_CODE: pkt.push_back(OptLease);
      D_TRUNC_VALUE: begin pkt.push_back(OptLease); pkt.push_back(8'd4); pkt.push_back(8'd1); end
      D_LONG: while (pkt.size() < MaxPacket + 3) pkt.push_back(OptPad);
      D_BCAST_DERIVED: add_word(OptNetmask, 32'hFFFF_F000);
      D_WRONG_SIZES: begin
        add_opt(OptNetmask, 3); add_opt(OptLease, 5); add_opt(OptMsgType, 2);
        add_opt(OptRouter, 7); add_opt(8'd99, 0);
      end
      D_AFTER_END: begin pkt.push_back(OptEnd); pkt.push_back(OptLease); end
      D_EXTREMES: begin
        for (int i = 16; i < 20; i++) pkt[i] = 8'hFF;
        pkt[242] = 8'hFF;
        add_word(OptLease, 32'hFFFF_FFFF); add_word(OptNetmask, 32'h0000_0001);
        add_opt(8'd254, 255);
        pkt.push_back(OptEnd);
      end
      default: ;
    endcase
    send_pkt();
    if (row.reject_known &&
        !(lease_fifo.size() >= 1 && lease_fifo[lease_fifo.size()-1] ===
          lease_item_t'{1'b1, FK_NONE, 2'd0, 32'd0, 1'b1})) begin
      errors++;
      $display("tb: case %s did not predict a reject", row.which.name());
    end
  endtask

  initial begin
    errors = 0; results_seen = 0; packets_sent = 0; rejects_seen = 0;
    idle_off = 0; hold_sink = 0; drain_wait = 0;
    xid_reg = '0; mac_reg = '0;
    clear_packet();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at reset value first, then the extremes.
    random_packet(0);
    drain();
    write_reg(CfgTransactionId, 48'hFFFF_FFFF);
    write_reg(CfgClientHwAddr, 48'hFFFF_FFFF_FFFF);
    foreach (dir_table[i]) directed_row(dir_table[i]);
    drain();
    write_reg(CfgTransactionId, 48'h0);
    write_reg(CfgClientHwAddr, 48'h0);
    random_packet(0);
    drain();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgTransactionId, {16'd0, $urandom});
      write_reg(CfgClientHwAddr, {16'($urandom), 32'($urandom)});
      idle_off = (ph == 2);
      for (int k = 0; k < 70; k++) begin
        if (ph == 1 && k == 10) begin
          // Receiver blocked for a long stretch while bytes keep coming.
          fork
            begin
              hold_sink = 1;
              repeat (1500) @(posedge clk_i);
              hold_sink = 0;
            end
          join_none
        end
        if (k == 35) begin
          // Sender waits until the outstanding run has fully drained.
          s_tvalid_i <= 1'b0;
          while (lease_fifo.size() != 0) @(posedge clk_i);
        end
        random_packet($urandom_range(4) == 0);
      end
      drain();
    end
    idle_off = 0;

    $display("tb: %0d packets sent, %0d result beats checked, %0d rejects",
             packets_sent, results_seen, rejects_seen);
    $display("tb: header, option walk, list limits, truncation and length cases driven");
    if (errors == 0 && lease_fifo.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches, %0d beats still expected", errors, lease_fifo.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/drp_pkg.sv
hdl/dhcp_reply_option_parser.sv
test/dhcp_reply_option_parser_tb.sv
